### rtl/rrtr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrtr_pkg - shared types for the round-robin task ring
// Field widths, op and status codes, and the controller/datapath interface.
// ----------------------------------------------------------------------------
package rrtr_pkg;

  localparam int ID_W    = 6;
  localparam int OP_W    = 2;
  localparam int ST_W    = 2;
  localparam int COUNT_W = 7;

  typedef enum logic [OP_W-1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_PICK   = 2'd2
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_ABSENT  = 2'd2,
    ST_PRESENT = 2'd3
  } status_t;

  // link RAM read address source
  typedef enum logic [1:0] {
    RA_TAIL = 2'd0,
    RA_ID   = 2'd1,
    RA_DATA = 2'd2
  } raddr_sel_t;

  // link RAM write address source
  typedef enum logic [1:0] {
    WA_ID   = 2'd0,
    WA_TAIL = 2'd1,
    WA_WALK = 2'd2
  } waddr_sel_t;

  // link RAM write data source
  typedef enum logic [1:0] {
    WD_ID   = 2'd0,
    WD_DATA = 2'd1,
    WD_SUCC = 2'd2
  } wdata_sel_t;

  typedef enum logic [1:0] {
    TL_HOLD = 2'd0,
    TL_ID   = 2'd1,
    TL_DATA = 2'd2,
    TL_WALK = 2'd3
  } tail_sel_t;

  typedef enum logic [1:0] {
    WL_HOLD = 2'd0,
    WL_TAIL = 2'd1,
    WL_DATA = 2'd2
  } walk_sel_t;

  typedef struct packed {
    logic       latch_id;
    raddr_sel_t raddr_sel;
    logic       we;
    waddr_sel_t waddr_sel;
    wdata_sel_t wdata_sel;
    logic       set_member;   // also bumps the count
    logic       clr_member;   // also drops the count
    tail_sel_t  tail_sel;
    walk_sel_t  walk_sel;
    logic       succ_ld;
    logic       emit;
    logic       pick_out;
    status_t    status;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic one_left;
    logic in_range;
    logic is_member;
    logic tail_is_id;
    logic walk_hit;
  } stat_t;

endpackage

### rtl/rrtr_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrtr_ram - generic single-write, single-read RAM
// One write port, one read port, read data registered. No reset.
// ----------------------------------------------------------------------------
module rrtr_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/rrtr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrtr_ctrl - sequencer for the task ring
// Decodes the op, steps through link reads/writes and the predecessor walk.
// ----------------------------------------------------------------------------
module rrtr_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [rrtr_pkg::OP_W-1:0] in_op,
  input  rrtr_pkg::stat_t           stat,
  output rrtr_pkg::cmd_t            cmd,
  output logic                      busy
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_NOP,
    S_ADD,
    S_ADD_LNK,
    S_ADD_TAIL,
    S_PICK,
    S_PICK_UPD,
    S_REM,
    S_REM_SUCC,
    S_REM_WALK
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    cmd.raddr_sel = rrtr_pkg::RA_TAIL;
    cmd.waddr_sel = rrtr_pkg::WA_ID;
    cmd.wdata_sel = rrtr_pkg::WD_ID;
    cmd.tail_sel  = rrtr_pkg::TL_HOLD;
    cmd.walk_sel  = rrtr_pkg::WL_HOLD;
    cmd.status    = rrtr_pkg::ST_OK;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.latch_id = 1'b1;
          case (in_op)
            rrtr_pkg::OP_ADD:    state_nxt = S_ADD;
            rrtr_pkg::OP_REMOVE: state_nxt = S_REM;
            rrtr_pkg::OP_PICK:   state_nxt = S_PICK;
            default:             state_nxt = S_NOP;
          endcase
        end
      end
      S_NOP: begin
        cmd.emit  = 1'b1;
        state_nxt = S_IDLE;
      end
      S_ADD: begin
        if (!stat.in_range) begin
          cmd.emit   = 1'b1;
          cmd.status = rrtr_pkg::ST_ABSENT;
          state_nxt  = S_IDLE;
        end else if (stat.is_member) begin
          cmd.emit   = 1'b1;
          cmd.status = rrtr_pkg::ST_PRESENT;
          state_nxt  = S_IDLE;
        end else if (stat.empty) begin
          // first task links to itself
          cmd.we         = 1'b1;
          cmd.waddr_sel  = rrtr_pkg::WA_ID;
          cmd.wdata_sel  = rrtr_pkg::WD_ID;
          cmd.set_member = 1'b1;
          cmd.tail_sel   = rrtr_pkg::TL_ID;
          cmd.emit       = 1'b1;
          state_nxt      = S_IDLE;
        end else begin
          cmd.raddr_sel = rrtr_pkg::RA_TAIL;
          state_nxt     = S_ADD_LNK;
        end
      end
      S_ADD_LNK: begin
        // link[id] = link[tail]
        cmd.we        = 1'b1;
        cmd.waddr_sel = rrtr_pkg::WA_ID;
        cmd.wdata_sel = rrtr_pkg::WD_DATA;
        state_nxt     = S_ADD_TAIL;
      end
      S_ADD_TAIL: begin
        // link[tail] = id, tail = id
        cmd.we         = 1'b1;
        cmd.waddr_sel  = rrtr_pkg::WA_TAIL;
        cmd.wdata_sel  = rrtr_pkg::WD_ID;
        cmd.set_member = 1'b1;
        cmd.tail_sel   = rrtr_pkg::TL_ID;
        cmd.emit       = 1'b1;
        state_nxt      = S_IDLE;
      end
      S_PICK: begin
        if (stat.empty) begin
          cmd.emit   = 1'b1;
          cmd.status = rrtr_pkg::ST_EMPTY;
          state_nxt  = S_IDLE;
        end else begin
          cmd.raddr_sel = rrtr_pkg::RA_TAIL;
          state_nxt     = S_PICK_UPD;
        end
      end
      S_PICK_UPD: begin
        cmd.tail_sel = rrtr_pkg::TL_DATA;
        cmd.pick_out = 1'b1;
        cmd.emit     = 1'b1;
        state_nxt    = S_IDLE;
      end
      S_REM: begin
        if (stat.empty) begin
          cmd.emit   = 1'b1;
          cmd.status = rrtr_pkg::ST_EMPTY;
          state_nxt  = S_IDLE;
        end else if (!stat.is_member) begin
          cmd.emit   = 1'b1;
          cmd.status = rrtr_pkg::ST_ABSENT;
          state_nxt  = S_IDLE;
        end else if (stat.one_left) begin
          cmd.clr_member = 1'b1;
          cmd.emit       = 1'b1;
          state_nxt      = S_IDLE;
        end else begin
          cmd.raddr_sel = rrtr_pkg::RA_ID;
          state_nxt     = S_REM_SUCC;
        end
      end
      S_REM_SUCC: begin
        // capture link[id], start the walk at the tail
        cmd.succ_ld   = 1'b1;
        cmd.raddr_sel = rrtr_pkg::RA_TAIL;
        cmd.walk_sel  = rrtr_pkg::WL_TAIL;
        state_nxt     = S_REM_WALK;
      end
      S_REM_WALK: begin
        if (stat.walk_hit) begin
          cmd.we         = 1'b1;
          cmd.waddr_sel  = rrtr_pkg::WA_WALK;
          cmd.wdata_sel  = rrtr_pkg::WD_SUCC;
          cmd.clr_member = 1'b1;
          cmd.tail_sel   = stat.tail_is_id ? rrtr_pkg::TL_WALK : rrtr_pkg::TL_HOLD;
          cmd.emit       = 1'b1;
          state_nxt      = S_IDLE;
        end else begin
          cmd.raddr_sel = rrtr_pkg::RA_DATA;
          cmd.walk_sel  = rrtr_pkg::WL_DATA;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

### rtl/rrtr_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrtr_dp - task ring datapath
// Link RAM, tail/walk/successor registers, membership bits, count, result.
// ----------------------------------------------------------------------------
module rrtr_dp #(
  parameter int MAX_TASKS = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [rrtr_pkg::ID_W-1:0]    in_task_id,
  input  rrtr_pkg::cmd_t               cmd,
  output rrtr_pkg::stat_t              stat,
  output logic                         out_valid,
  output logic [rrtr_pkg::ID_W-1:0]    out_picked_task,
  output logic                         out_picked_valid,
  output logic [rrtr_pkg::ST_W-1:0]    out_status,
  output logic [rrtr_pkg::COUNT_W-1:0] out_ring_count
);

  // only ids below both the field range and MAX_TASKS can ever be members
  localparam int SLOTS  = (MAX_TASKS < (1 << rrtr_pkg::ID_W)) ? MAX_TASKS
                                                              : (1 << rrtr_pkg::ID_W);
  localparam int SLOT_W = $clog2(SLOTS);

  logic [rrtr_pkg::ID_W-1:0]    id_r;
  logic [SLOT_W-1:0]            tail_r, tail_nxt;
  logic [SLOT_W-1:0]            walk_r, walk_nxt;
  logic [SLOT_W-1:0]            succ_r;
  logic [SLOTS-1:0]             member_r;
  logic [rrtr_pkg::COUNT_W-1:0] total_r, total_nxt;

  logic                         out_valid_r;
  logic [rrtr_pkg::ID_W-1:0]    out_picked_task_r;
  logic                         out_picked_valid_r;
  logic [rrtr_pkg::ST_W-1:0]    out_status_r;
  logic [rrtr_pkg::COUNT_W-1:0] out_ring_count_r;

  logic [SLOT_W-1:0] id_idx;
  logic [SLOT_W-1:0] rd_data;
  logic [SLOT_W-1:0] raddr, waddr, wdata;

  assign id_idx = SLOT_W'(id_r);

  rrtr_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (SLOTS)
  ) u_link_ram (
    .clk   (clk),
    .we    (cmd.we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rd_data)
  );

  always_comb begin
    case (cmd.raddr_sel)
      rrtr_pkg::RA_TAIL: raddr = tail_r;
      rrtr_pkg::RA_ID:   raddr = id_idx;
      rrtr_pkg::RA_DATA: raddr = rd_data;
      default:           raddr = tail_r;
    endcase
    case (cmd.waddr_sel)
      rrtr_pkg::WA_ID:   waddr = id_idx;
      rrtr_pkg::WA_TAIL: waddr = tail_r;
      rrtr_pkg::WA_WALK: waddr = walk_r;
      default:           waddr = id_idx;
    endcase
    case (cmd.wdata_sel)
      rrtr_pkg::WD_ID:   wdata = id_idx;
      rrtr_pkg::WD_DATA: wdata = rd_data;
      rrtr_pkg::WD_SUCC: wdata = succ_r;
      default:           wdata = id_idx;
    endcase
    case (cmd.tail_sel)
      rrtr_pkg::TL_ID:   tail_nxt = id_idx;
      rrtr_pkg::TL_DATA: tail_nxt = rd_data;
      rrtr_pkg::TL_WALK: tail_nxt = walk_r;
      default:           tail_nxt = tail_r;
    endcase
    case (cmd.walk_sel)
      rrtr_pkg::WL_TAIL: walk_nxt = tail_r;
      rrtr_pkg::WL_DATA: walk_nxt = rd_data;
      default:           walk_nxt = walk_r;
    endcase
  end

  always_comb begin
    total_nxt = total_r;
    if (cmd.set_member) begin
      total_nxt = total_r + rrtr_pkg::COUNT_W'(1);
    end else if (cmd.clr_member) begin
      total_nxt = total_r - rrtr_pkg::COUNT_W'(1);
    end
  end

  always_comb begin
    stat.empty      = (total_r == '0);
    stat.one_left   = (total_r == rrtr_pkg::COUNT_W'(1));
    stat.in_range   = (32'(id_r) < 32'(SLOTS));
    stat.is_member  = stat.in_range && member_r[id_idx];
    stat.tail_is_id = (tail_r == id_idx);
    stat.walk_hit   = (rd_data == id_idx);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tail_r      <= '0;
      member_r    <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      tail_r      <= tail_nxt;
      total_r     <= total_nxt;
      out_valid_r <= cmd.emit;
      if (cmd.set_member) begin
        member_r[id_idx] <= 1'b1;
      end else if (cmd.clr_member) begin
        member_r[id_idx] <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    walk_r <= walk_nxt;
    if (cmd.latch_id) begin
      id_r <= in_task_id;
    end
    if (cmd.succ_ld) begin
      succ_r <= rd_data;
    end
    if (cmd.emit) begin
      out_picked_task_r  <= cmd.pick_out ? rrtr_pkg::ID_W'(rd_data) : '0;
      out_picked_valid_r <= cmd.pick_out;
      out_status_r       <= cmd.status;
      out_ring_count_r   <= total_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_picked_task  = out_picked_task_r;
  assign out_picked_valid = out_picked_valid_r;
  assign out_status       = out_status_r;
  assign out_ring_count   = out_ring_count_r;

endmodule

### rtl/round_robin_task_ring_unit.sv
`timescale 1ns / 1ps
// One beat out per beat in; busy is high from the accept until the result beat is shown, so
// the next start is taken in the cycle that out_valid is high. The link RAM has one read port
// and one write port, one access each per cycle: add needs two link writes, and remove walks
// the ring one link a cycle from the tail to the predecessor. The receiver cannot stall. Sync
// reset empties ring.
// ----------------------------------------------------------------------------
// round_robin_task_ring_unit - round-robin ready ring of task numbers
// Circular singly linked list held in a link RAM with a tail pointer. Add
// inserts after the tail, remove unlinks via a predecessor walk, pick
// advances the tail and returns the new tail task.
// ----------------------------------------------------------------------------
module round_robin_task_ring_unit #(
  parameter int MAX_TASKS = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // command beat
  input  logic                         start,
  output logic                         busy,
  input  logic [rrtr_pkg::OP_W-1:0]    in_op,
  input  logic [rrtr_pkg::ID_W-1:0]    in_task_id,
  // result beat, one cycle wide
  output logic                         out_valid,
  output logic [rrtr_pkg::ID_W-1:0]    out_picked_task,
  output logic                         out_picked_valid,
  output logic [rrtr_pkg::ST_W-1:0]    out_status,
  output logic [rrtr_pkg::COUNT_W-1:0] out_ring_count
);

  // ring can hold at most this many tasks (ids are six bits wide)
  localparam int SLOTS = (MAX_TASKS < (1 << rrtr_pkg::ID_W)) ? MAX_TASKS
                                                             : (1 << rrtr_pkg::ID_W);

  rrtr_pkg::cmd_t  cmd;
  rrtr_pkg::stat_t stat;

  // Controller: op decode, link read/write sequencing, predecessor walk.
  rrtr_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .in_op (in_op),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // Datapath: link RAM, tail, membership bits, count and the result register.
  rrtr_dp #(
    .MAX_TASKS (MAX_TASKS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_task_id       (in_task_id),
    .cmd              (cmd),
    .stat             (stat),
    .out_valid        (out_valid),
    .out_picked_task  (out_picked_task),
    .out_picked_valid (out_picked_valid),
    .out_status       (out_status),
    .out_ring_count   (out_ring_count)
  );

  // The result beat is shown only once the sequencer has gone back to idle.
  a_out_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result beat while sequencer busy");

  // An accepted command always raises busy in the following cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted command did not raise busy");

  // A picked task only comes with an ok status.
  a_pick_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_picked_valid) |-> (out_status == rrtr_pkg::ST_OK))
    else $error("pick result with error status");

  // Count never exceeds the number of slots.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_ring_count) <= 32'(SLOTS)))
    else $error("ring count above slot count");

endmodule

### bench/tb_round_robin_task_ring_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_round_robin_task_ring_unit - self-checking bench for the round-robin ring
// Sends add, remove and pick beats through the start/busy handshake, predicts
// each result beat from a shadow copy of the ring, and checks every out_valid
// beat in order against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_round_robin_task_ring_unit;

  localparam int RING_SLOTS = 64;
  // no-op code, not in op_t
  localparam logic [rrtr_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
  // Remove walks at most the whole ring, one link a cycle; this clears any tail.
  localparam int DRAIN_CYCLES = 4 * RING_SLOTS;
  localparam int MAX_SHOWN = 10;
  localparam int IDLE_PCT = 9;

  typedef struct packed {
    logic [rrtr_pkg::ID_W-1:0]    picked_task;
    logic                         picked_valid;
    rrtr_pkg::status_t            status;
    logic [rrtr_pkg::COUNT_W-1:0] ring_count;
  } ring_reply_t;

  logic                         clk;
  logic                         rst_n;
  logic                         start;
  logic                         busy;
  logic [rrtr_pkg::OP_W-1:0]    in_op;
  logic [rrtr_pkg::ID_W-1:0]    in_task_id;
  logic                         out_valid;
  logic [rrtr_pkg::ID_W-1:0]    out_picked_task;
  logic                         out_picked_valid;
  logic [rrtr_pkg::ST_W-1:0]    out_status;
  logic [rrtr_pkg::COUNT_W-1:0] out_ring_count;

  round_robin_task_ring_unit #(
    .MAX_TASKS(RING_SLOTS)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_op            (in_op),
    .in_task_id       (in_task_id),
    .out_valid        (out_valid),
    .out_picked_task  (out_picked_task),
    .out_picked_valid (out_picked_valid),
    .out_status       (out_status),
    .out_ring_count   (out_ring_count)
  );

  // Shadow ring: successor links, tail task, membership and size.
  logic [rrtr_pkg::ID_W-1:0] succ_of [RING_SLOTS];
  logic [rrtr_pkg::ID_W-1:0] tail_task;
  bit                        in_ring [RING_SLOTS];
  int unsigned               ring_size;

  ring_reply_t awaited_replies [$];

  bit          gaps_on;
  int unsigned fault_count;
  int unsigned shown_faults;
  int unsigned replies_checked;
  int unsigned op_tally [4];
  int unsigned rejected_beats;
  int unsigned peak_size;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog: far beyond the slowest legal run (every beat a full-ring walk
  // plus the longest sender gap).
  initial begin
    #10_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Applies one op to the shadow ring and returns the result beat it yields.
  function automatic ring_reply_t apply_ring_op(logic [rrtr_pkg::OP_W-1:0] op,
                                                logic [rrtr_pkg::ID_W-1:0] id);
    ring_reply_t               r;
    logic [rrtr_pkg::ID_W-1:0] walk;
    logic [rrtr_pkg::ID_W-1:0] nxt;
    int unsigned               steps;
    bit                        done;
    r = '0;
    case (op)
      rrtr_pkg::OP_ADD: begin
        if (in_ring[id]) begin
          r.status = rrtr_pkg::ST_PRESENT;
        end else begin
          // first task links to itself; later ones splice in after the tail
          if (ring_size == 0) begin
            succ_of[id] = id;
          end else begin
            succ_of[id]        = succ_of[tail_task];
            succ_of[tail_task] = id;
          end
          tail_task   = id;
          in_ring[id] = 1'b1;
          ring_size++;
        end
      end
      rrtr_pkg::OP_REMOVE: begin
        if (ring_size == 0) begin
          r.status = rrtr_pkg::ST_EMPTY;
        end else if (!in_ring[id]) begin
          r.status = rrtr_pkg::ST_ABSENT;
        end else begin
          // find the predecessor by walking from the tail, then unlink
          if (ring_size > 1) begin
            walk  = tail_task;
            steps = 0;
            done  = 1'b0;
            while (!done && steps < RING_SLOTS) begin
              nxt = succ_of[walk];
              if (nxt == id) begin
                succ_of[walk] = succ_of[id];
                if (tail_task == id) tail_task = walk;
                done = 1'b1;
              end
              walk = nxt;
              steps++;
            end
          end
          // tail keeps a stale value once the ring runs empty
          in_ring[id] = 1'b0;
          ring_size--;
        end
      end
      rrtr_pkg::OP_PICK: begin
        if (ring_size == 0) begin
          r.status = rrtr_pkg::ST_EMPTY;
        end else begin
          tail_task      = succ_of[tail_task];
          r.picked_task  = tail_task;
          r.picked_valid = 1'b1;
        end
      end
      default: ;
    endcase
    r.ring_count = rrtr_pkg::COUNT_W'(ring_size);
    return r;
  endfunction

  function automatic logic [rrtr_pkg::ID_W-1:0] rand_task_id();
    return rrtr_pkg::ID_W'($urandom_range(RING_SLOTS - 1, 0));
  endfunction

  // Random task whose membership matches want_member; any task if none does.
  function automatic logic [rrtr_pkg::ID_W-1:0] pick_task(bit want_member);
    int unsigned               base;
    int unsigned               k;
    logic [rrtr_pkg::ID_W-1:0] found;
    bit                        hit;
    base  = $urandom_range(RING_SLOTS - 1, 0);
    found = rrtr_pkg::ID_W'(base);
    hit   = 1'b0;
    for (k = 0; k < RING_SLOTS; k++) begin
      if (!hit && in_ring[(base + k) % RING_SLOTS] == want_member) begin
        found = rrtr_pkg::ID_W'((base + k) % RING_SLOTS);
        hit   = 1'b1;
      end
    end
    return found;
  endfunction

  // One command beat. Inputs move on the falling edge only; start stays high across
  // back-to-back beats. The beat is taken at the first rising edge with busy low, and
  // its prediction is queued right there.
  task automatic send_beat(input logic [rrtr_pkg::OP_W-1:0] op,
                           input logic [rrtr_pkg::ID_W-1:0] id);
    int unsigned gap;
    ring_reply_t want;
    gap = 0;
    if (gaps_on && $urandom_range(99, 0) < IDLE_PCT) gap = $urandom_range(12, 1);
    if (gap != 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start      <= 1'b1;
    in_op      <= op;
    in_task_id <= id;
    @(posedge clk);
    while (busy) @(posedge clk);
    want = apply_ring_op(op, id);
    awaited_replies.push_back(want);
    op_tally[op]++;
    if (want.status != rrtr_pkg::ST_OK) rejected_beats++;
    if (ring_size > peak_size) peak_size = ring_size;
  endtask

  task automatic note_fault(input string what, input ring_reply_t want,
                            input ring_reply_t got);
    fault_count++;
    if (shown_faults < MAX_SHOWN) begin
      shown_faults++;
      $display("%0t: %s: exp task=%0d valid=%0b status=%0d count=%0d",
               $realtime, what, want.picked_task, want.picked_valid, want.status,
               want.ring_count);
      $display("%0t: %s: got task=%0d valid=%0b status=%0d count=%0d",
               $realtime, what, got.picked_task, got.picked_valid, got.status,
               got.ring_count);
    end
  endtask

  // Result beats last one cycle and cannot be held off: sample each one at the
  // rising edge that ends it and match it to the oldest prediction.
  always @(posedge clk) begin : check_replies
    ring_reply_t got;
    ring_reply_t want;
    if (rst_n && out_valid) begin
      got = {out_picked_task, out_picked_valid, rrtr_pkg::status_t'(out_status),
             out_ring_count};
      if (awaited_replies.size() == 0) begin
        note_fault("result beat with none outstanding", '0, got);
      end else begin
        want = awaited_replies.pop_front();
        replies_checked++;
        if (got !== want) note_fault("result mismatch", want, got);
      end
    end
  end

  // --- directed ---------------------------------------------------------------

  // Every op on an empty ring, task number extremes on remove.
  task automatic test_empty_ring();
    send_beat(rrtr_pkg::OP_PICK, rand_task_id());
    send_beat(rrtr_pkg::OP_REMOVE, rrtr_pkg::ID_W'(0));
    send_beat(rrtr_pkg::OP_REMOVE, rrtr_pkg::ID_W'(RING_SLOTS - 1));
    send_beat(OP_UNUSED, rrtr_pkg::ID_W'(RING_SLOTS - 1));
  endtask

  // One-task ring: duplicate add, remove of another task leaves it, picks wrap
  // to itself, removing the right task empties it.
  task automatic test_single_task();
    send_beat(rrtr_pkg::OP_ADD, rrtr_pkg::ID_W'(RING_SLOTS - 1));
    send_beat(rrtr_pkg::OP_ADD, rrtr_pkg::ID_W'(RING_SLOTS - 1));
    send_beat(rrtr_pkg::OP_REMOVE, rrtr_pkg::ID_W'(0));
    send_beat(rrtr_pkg::OP_PICK, rrtr_pkg::ID_W'(0));
    send_beat(rrtr_pkg::OP_PICK, rrtr_pkg::ID_W'(RING_SLOTS - 1));
    send_beat(rrtr_pkg::OP_REMOVE, rrtr_pkg::ID_W'(RING_SLOTS - 1));
    send_beat(rrtr_pkg::OP_PICK, rrtr_pkg::ID_W'(0));
  endtask

  // Round-robin order, removing a middle task and the tail, absent remove,
  // the unused op on a live ring.
  task automatic test_ring_order();
    send_beat(rrtr_pkg::OP_ADD, rrtr_pkg::ID_W'(0));
    send_beat(rrtr_pkg::OP_ADD, rrtr_pkg::ID_W'(42));
    send_beat(rrtr_pkg::OP_ADD, rrtr_pkg::ID_W'(21));
    send_beat(rrtr_pkg::OP_ADD, rrtr_pkg::ID_W'(RING_SLOTS - 1));
    send_beat(rrtr_pkg::OP_PICK, rrtr_pkg::ID_W'(0));
    send_beat(rrtr_pkg::OP_PICK, rrtr_pkg::ID_W'(0));
    send_beat(rrtr_pkg::OP_REMOVE, rrtr_pkg::ID_W'(21));
    send_beat(rrtr_pkg::OP_REMOVE, rrtr_pkg::ID_W'(42));
    send_beat(rrtr_pkg::OP_REMOVE, rrtr_pkg::ID_W'(7));
    send_beat(OP_UNUSED, rrtr_pkg::ID_W'(21));
    send_beat(rrtr_pkg::OP_PICK, rrtr_pkg::ID_W'(RING_SLOTS - 1));
    send_beat(rrtr_pkg::OP_REMOVE, rrtr_pkg::ID_W'(0));
    send_beat(rrtr_pkg::OP_REMOVE, rrtr_pkg::ID_W'(RING_SLOTS - 1));
  endtask

  // --- random -----------------------------------------------------------------

  // Full ring (count 64), duplicate add at full, then drain in random order
  // with picks mixed in.
  task automatic test_fill_and_drain();
    while (ring_size < RING_SLOTS) send_beat(rrtr_pkg::OP_ADD, pick_task(1'b0));
    send_beat(rrtr_pkg::OP_ADD, rand_task_id());
    repeat (8) send_beat(rrtr_pkg::OP_PICK, rand_task_id());
    while (ring_size != 0) begin
      if ($urandom_range(99, 0) < 15) send_beat(rrtr_pkg::OP_PICK, rand_task_id());
      else send_beat(rrtr_pkg::OP_REMOVE, pick_task(1'b1));
    end
  endtask

  // Mostly well-formed traffic (adds of absent tasks, removes of members) with
  // some duplicate adds, stray removes and unused ops; add_pct steers the size.
  task automatic test_random_churn(input int unsigned beats, input int unsigned add_pct);
    int unsigned roll;
    int unsigned aim;
    repeat (beats) begin
      roll = $urandom_range(99, 0);
      aim  = $urandom_range(99, 0);
      if (roll < add_pct) begin
        send_beat(rrtr_pkg::OP_ADD, (aim < 85) ? pick_task(1'b0) : rand_task_id());
      end else begin
        roll = $urandom_range(99, 0);
        if (roll < 50) begin
          send_beat(rrtr_pkg::OP_REMOVE, (aim < 85) ? pick_task(1'b1) : rand_task_id());
        end else if (roll < 95) begin
          send_beat(rrtr_pkg::OP_PICK, rand_task_id());
        end else begin
          send_beat(OP_UNUSED, rand_task_id());
        end
      end
    end
  endtask

  // Stop driving and wait for every outstanding result, then let the block
  // settle for longer than its deepest walk.
  task automatic wait_for_quiet();
    int unsigned guard;
    guard = 0;
    @(negedge clk);
    start <= 1'b0;
    while (awaited_replies.size() != 0 && guard < 100_000) begin
      @(posedge clk);
      guard++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    rst_n           = 1'b0;
    start           = 1'b0;
    in_op           = rrtr_pkg::OP_ADD;
    in_task_id      = '0;
    gaps_on         = 1'b1;
    fault_count     = 0;
    shown_faults    = 0;
    replies_checked = 0;
    rejected_beats  = 0;
    peak_size       = 0;
    ring_size       = 0;
    tail_task       = '0;
    foreach (in_ring[i]) in_ring[i] = 1'b0;
    foreach (succ_of[i]) succ_of[i] = '0;
    foreach (op_tally[i]) op_tally[i] = 0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_ring();
    test_single_task();
    test_ring_order();
    test_fill_and_drain();
    test_random_churn(260, 70);   // grow
    gaps_on = 1'b0;               // long stretch without sender gaps
    test_random_churn(230, 45);
    gaps_on = 1'b1;
    test_random_churn(260, 50);
    test_random_churn(230, 20);   // shrink toward empty
    test_fill_and_drain();

    wait_for_quiet();
    if (awaited_replies.size() != 0) begin
      fault_count += awaited_replies.size();
      $display("%0d predicted results never arrived", awaited_replies.size());
    end

    $display("covered %0d beats: %0d add, %0d remove, %0d pick, %0d unused op",
             op_tally[0] + op_tally[1] + op_tally[2] + op_tally[3],
             op_tally[rrtr_pkg::OP_ADD], op_tally[rrtr_pkg::OP_REMOVE],
             op_tally[rrtr_pkg::OP_PICK], op_tally[OP_UNUSED]);
    $display("%0d results checked, %0d rejected by status, peak ring size %0d, %0d faults",
             replies_checked, rejected_beats, peak_size, fault_count);
    if (fault_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
